/* sv/lcd4_pkg.sv */
// Package for the 4-bit character-LCD bus sequencer.
// Holds the request and branch codes, the control word type, the microcode ROM
// and the entry decoder. It depends on nothing.
package lcd4_pkg;

  localparam int LineCharsDef = 16;
  localparam int PcW          = 5;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_CHAR      = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_CURSOR    = 3'd3,
    CMD_BACKLIGHT = 3'd4,
    CMD_POS       = 3'd5
  } cmd_e;

  localparam logic [1:0] OPT_OFF   = 2'd0;
  localparam logic [1:0] OPT_ON    = 2'd1;
  localparam logic [1:0] OPT_ALL   = 2'd0;
  localparam logic [1:0] OPT_LINE1 = 2'd1;
  localparam logic [1:0] OPT_LINE2 = 2'd2;

  typedef enum logic [1:0] {
    BR_NEXT = 2'd0,
    BR_END  = 2'd1,
    BR_LOOP = 2'd2
  } br_e;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_CHAR  = 2'd1,
    SRC_POS   = 2'd2
  } src_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    br_e        br;
    src_e       src;
    logic       hi;
    logic       rs;
    logic       strobe;
    logic [3:0] wait_ms;
    logic [7:0] data;
    pc_t        target;
  } word_t;

  typedef struct packed {
    logic  req_load;
    logic  step_load;
    word_t word;
  } dp_ctl_t;

  typedef struct packed {
    logic run;
    pc_t  pc;
  } entry_t;

  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_DISP_CUR  = 8'h0F;
  localparam logic [7:0] LCD_DISP_NCUR = 8'h0C;
  localparam logic [7:0] LCD_CLEAR     = 8'h01;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_HOME_POS  = 8'h87;
  localparam logic [7:0] LCD_SPACE     = 8'h20;
  localparam logic [7:0] LCD_WAKE      = 8'h03;
  localparam logic [7:0] LCD_4BIT      = 8'h02;
  localparam logic [7:0] LCD_NONE      = 8'h00;

  localparam pc_t PC_INIT       = 5'd0;
  localparam pc_t PC_CHAR       = 5'd15;
  localparam pc_t PC_CLR_ALL    = 5'd17;
  localparam pc_t PC_CLR_LINE   = 5'd19;
  localparam pc_t PC_SPACE_LOOP = 5'd21;
  localparam pc_t PC_PIN        = 5'd25;
  localparam pc_t PC_CUR_ON     = 5'd26;
  localparam pc_t PC_CUR_OFF    = 5'd28;
  localparam pc_t PC_POS        = 5'd30;

  function automatic word_t mk(br_e br, src_e src, logic hi, logic rs, logic strobe,
                               logic [3:0] wait_ms, logic [7:0] data);
    word_t w;
    w.br      = br;
    w.src     = src;
    w.hi      = hi;
    w.rs      = rs;
    w.strobe  = strobe;
    w.wait_ms = wait_ms;
    w.data    = data;
    w.target  = PC_SPACE_LOOP;
    return w;
  endfunction

  function automatic word_t lcd4_rom(pc_t pc);
    word_t w;
    w = mk(BR_END, SRC_CONST, 1'b0, 1'b0, 1'b0, 4'd1, LCD_NONE);
    case (pc)
      5'd0:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b0, 4'd15, LCD_NONE);
      5'd1:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd5, LCD_WAKE);
      5'd2:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_WAKE);
      5'd3:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_WAKE);
      5'd4:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_4BIT);
      5'd5:  w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_FUNC_SET);
      5'd6:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_FUNC_SET);
      5'd7:  w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_DISP_CUR);
      5'd8:  w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_DISP_CUR);
      5'd9:  w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_CLEAR);
      5'd10: w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd2, LCD_CLEAR);
      5'd11: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_ENTRY);
      5'd12: w = mk(BR_NEXT, SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_ENTRY);
      5'd13: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_HOME_POS);
      5'd14: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_HOME_POS);
      5'd15: w = mk(BR_NEXT, SRC_CHAR,  1'b1, 1'b1, 1'b1, 4'd0, LCD_NONE);
      5'd16: w = mk(BR_END,  SRC_CHAR,  1'b0, 1'b1, 1'b1, 4'd1, LCD_NONE);
      5'd17: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_CLEAR);
      5'd18: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_CLEAR);
      5'd19: w = mk(BR_NEXT, SRC_POS,   1'b1, 1'b0, 1'b1, 4'd0, LCD_NONE);
      5'd20: w = mk(BR_NEXT, SRC_POS,   1'b0, 1'b0, 1'b1, 4'd1, LCD_NONE);
      5'd21: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b1, 1'b1, 4'd0, LCD_SPACE);
      5'd22: w = mk(BR_LOOP, SRC_CONST, 1'b0, 1'b1, 1'b1, 4'd1, LCD_SPACE);
      5'd23: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b1, 1'b1, 4'd0, LCD_SPACE);
      5'd24: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b1, 1'b1, 4'd2, LCD_SPACE);
      5'd25: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b0, 1'b0, 4'd1, LCD_NONE);
      5'd26: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_DISP_CUR);
      5'd27: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_DISP_CUR);
      5'd28: w = mk(BR_NEXT, SRC_CONST, 1'b1, 1'b0, 1'b1, 4'd0, LCD_DISP_NCUR);
      5'd29: w = mk(BR_END,  SRC_CONST, 1'b0, 1'b0, 1'b1, 4'd1, LCD_DISP_NCUR);
      5'd30: w = mk(BR_NEXT, SRC_POS,   1'b1, 1'b0, 1'b1, 4'd0, LCD_NONE);
      5'd31: w = mk(BR_END,  SRC_POS,   1'b0, 1'b0, 1'b1, 4'd1, LCD_NONE);
      default: w = mk(BR_END, SRC_CONST, 1'b0, 1'b0, 1'b0, 4'd1, LCD_NONE);
    endcase
    return w;
  endfunction

  function automatic entry_t lcd4_entry(logic [2:0] cmd, logic [1:0] opt);
    entry_t e;
    e.run = 1'b1;
    e.pc  = PC_PIN;
    unique case (cmd_e'(cmd))
      CMD_INIT:      e.pc = PC_INIT;
      CMD_CHAR:      e.pc = PC_CHAR;
      CMD_CLEAR: begin
        if (opt == OPT_ALL) begin
          e.pc = PC_CLR_ALL;
        end else if (opt == OPT_LINE1 || opt == OPT_LINE2) begin
          e.pc = PC_CLR_LINE;
        end
      end
      CMD_CURSOR: begin
        if (opt == OPT_ON) begin
          e.pc = PC_CUR_ON;
        end else if (opt == OPT_OFF) begin
          e.pc = PC_CUR_OFF;
        end
      end
      CMD_BACKLIGHT: e.pc = PC_PIN;
      CMD_POS:       e.pc = PC_POS;
      default:       e.run = 1'b0;
    endcase
    return e;
  endfunction

endpackage

/* sv/lcd4_seq.sv */
// Microcode sequencer: step counter, space loop counter and request handshake.
// Reads the control ROM from lcd4_pkg and drives the datapath through dp_ctl_t.
module lcd4_seq import lcd4_pkg::*; #(
  parameter int LineChars = LineCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [1:0] option_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  output dp_ctl_t    ctl_o
);

  localparam int CntW = $clog2(LineChars - 1);

  seq_state_e      state_q, state_d;
  pc_t             pc_q, pc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  word_t           word;
  entry_t          ent;
  logic            accept;
  logic            advance;

  assign word   = lcd4_rom(pc_q);
  assign ent    = lcd4_entry(cmd_i, option_i);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && ent.run) state_d = ST_RUN;
      ST_RUN:  if (advance && word.br == BR_END) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    advance    = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  advance    = !out_valid_i || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    if (accept) begin
      pc_d  = ent.pc;
      cnt_d = '0;
    end else if (advance) begin
      pc_d = pc_q + 1'b1;
      if (word.br == BR_LOOP && cnt_q != CntW'(LineChars - 2)) begin
        pc_d  = word.target;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  assign ctl_o.req_load  = accept;
  assign ctl_o.step_load = advance;
  assign ctl_o.word      = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      cnt_q   <= cnt_d;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && out_valid_i && !out_ready_i |=> $stable(pc_q))
    else $error("step advanced while the output was stalled");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(LineChars - 2))
    else $error("space loop counter out of range");

  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && advance && word.br != BR_END |=> state_q == ST_RUN)
    else $error("run left before its final step");

endmodule

/* sv/lcd4_dp.sv */
// Datapath: request latches, backlight flag, byte and nibble selection and the
// result register. Controlled by dp_ctl_t from lcd4_seq; types from lcd4_pkg.
module lcd4_dp import lcd4_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_ctl_t    ctl_i,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_code_i,
  input  logic [1:0] option_i,
  input  logic       line_sel_i,
  input  logic [5:0] column_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [3:0] nibble_o,
  output logic       reg_select_o,
  output logic       strobe_res_o,
  output logic       backlight_o,
  output logic [3:0] wait_ms_o,
  output logic       last_o
);

  logic       out_valid_q, out_valid_d;
  logic       bl_q, bl_d;
  logic [7:0] char_q;
  logic [7:0] pos_q, pos_d;
  logic [7:0] sel;
  logic [3:0] nibble_q;
  logic       rs_q, strobe_q, bl_out_q, last_q;
  logic [3:0] wait_q;

  always_comb begin
    bl_d = bl_q;
    if (ctl_i.req_load) begin
      if (cmd_i == CMD_INIT) begin
        bl_d = 1'b1;
      end else if (cmd_i == CMD_BACKLIGHT && option_i == OPT_ON) begin
        bl_d = 1'b1;
      end else if (cmd_i == CMD_BACKLIGHT && option_i == OPT_OFF) begin
        bl_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd_i == CMD_CLEAR) begin
      pos_d = {1'b1, option_i == OPT_LINE2, 6'd0};
    end else begin
      pos_d = {1'b1, line_sel_i, column_i};
    end
  end

  always_comb begin
    case (ctl_i.word.src)
      SRC_CHAR: sel = char_q;
      SRC_POS:  sel = pos_q;
      default:  sel = ctl_i.word.data;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.step_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bl_q        <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      bl_q        <= bl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.req_load) begin
      char_q <= char_code_i;
      pos_q  <= pos_d;
    end
    if (ctl_i.step_load) begin
      nibble_q <= ctl_i.word.hi ? sel[7:4] : sel[3:0];
      rs_q     <= ctl_i.word.rs;
      strobe_q <= ctl_i.word.strobe;
      bl_out_q <= bl_q;
      wait_q   <= ctl_i.word.wait_ms;
      last_q   <= ctl_i.word.br == BR_END;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign nibble_o     = nibble_q;
  assign reg_select_o = rs_q;
  assign strobe_res_o = strobe_q;
  assign backlight_o  = bl_out_q;
  assign wait_ms_o    = wait_q;
  assign last_o       = last_q;

endmodule

/* sv/char_lcd_4bit_interface_top.sv */
// Top level of the 4-bit character-LCD bus sequencer; joins lcd4_seq and lcd4_dp.
// Throughput: one ROM step per cycle while the output is not stalled.
// A request of N results (1 to 34; a reserved command gives none) holds the sequencer until
// its final step loads, and the next request is taken in the cycle after the final step loads.
// The last result waits in the output register while the next request is accepted.
// Reset: backlight flag off, sequencer idle, output register empty.
module char_lcd_4bit_interface_top import lcd4_pkg::*; #(
  parameter int LINE_CHARS = LineCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_code_i,
  input  logic [1:0] option_i,
  input  logic       line_sel_i,
  input  logic [5:0] column_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] nibble_o,
  output logic       reg_select_o,
  output logic       strobe_res_o,
  output logic       backlight_o,
  output logic [3:0] wait_ms_o,
  output logic       last_o
);

  dp_ctl_t ctl;

  lcd4_seq #(
    .LineChars(LINE_CHARS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .option_i   (option_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctl_o      (ctl)
  );

  lcd4_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .option_i    (option_i),
    .line_sel_i  (line_sel_i),
    .column_i    (column_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .nibble_o    (nibble_o),
    .reg_select_o(reg_select_o),
    .strobe_res_o(strobe_res_o),
    .backlight_o (backlight_o),
    .wait_ms_o   (wait_ms_o),
    .last_o      (last_o)
  );

endmodule

/* sim/tb_top.sv */
// Self-checking bench for char_lcd_4bit_interface_top: request stream in, nibble stream out.
// Expected bus transfers are computed in-bench and compared field by field at the output.
// Depends on lcd4_pkg and the sequencer RTL only.
module tb_top;
  import lcd4_pkg::*;

  localparam int LineChars = LineCharsDef;
  localparam int RandItems = 400;
  localparam int IdleLimit = 2000;
  localparam int PrintCap  = 60;

  localparam logic [2:0] CMD_RSVD6  = 3'd6;
  localparam logic [2:0] CMD_RSVD7  = 3'd7;
  localparam logic [1:0] OPT_RSVD2  = 2'd2;
  localparam logic [1:0] OPT_RSVD3  = 2'd3;
  localparam logic [7:0] POS_BASE   = 8'h80;
  localparam logic [6:0] LINE2_BASE = 7'h40;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] ch;
    logic [1:0] opt;
    logic       line_sel;
    logic [5:0] column;
    logic [1:0] gap;
    logic       drain;
  } lcd_req_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       strobe;
    logic       bl;
    logic [3:0] wait_ms;
    logic       last;
  } bus_xfer_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic [2:0] cmd_i        = '0;
  logic [7:0] char_code_i  = '0;
  logic [1:0] option_i     = '0;
  logic       line_sel_i   = 1'b0;
  logic [5:0] column_i     = '0;
  logic       out_ready_i  = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [3:0] nibble_o;
  logic       reg_select_o;
  logic       strobe_res_o;
  logic       backlight_o;
  logic [3:0] wait_ms_o;
  logic       last_o;

  lcd_req_t  request_q[$];
  lcd_req_t  cur_req;
  bus_xfer_t run_q[$];
  bus_xfer_t lcd_bus_q[$];
  logic      backlight_q = 1'b0;
  logic      send_quiet  = 1'b0;
  int        err_cnt     = 0;
  int        hold_cnt    = 0;
  int        stall_cnt   = 0;
  int        idle_cycles = 0;

  char_lcd_4bit_interface_top #(
    .LINE_CHARS(LineChars)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .option_i    (option_i),
    .line_sel_i  (line_sel_i),
    .column_i    (column_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .nibble_o    (nibble_o),
    .reg_select_o(reg_select_o),
    .strobe_res_o(strobe_res_o),
    .backlight_o (backlight_o),
    .wait_ms_o   (wait_ms_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    err_cnt++;
    if (err_cnt <= PrintCap) begin
      $display("[%0t] lcd bus mismatch: %s got %0d want %0d", $time, what, got, want);
    end
  endtask

  task automatic add_xfer(logic [3:0] nib, logic rs, logic strobe, logic [3:0] wt);
    bus_xfer_t x;
    x.nibble  = nib;
    x.rs      = rs;
    x.strobe  = strobe;
    x.bl      = backlight_q;
    x.wait_ms = wt;
    x.last    = 1'b0;
    run_q.push_back(x);
  endtask

  task automatic add_byte(logic [7:0] b, logic rs, logic [3:0] wt);
    add_xfer(b[7:4], rs, 1'b1, 4'd0);
    add_xfer(b[3:0], rs, 1'b1, wt);
  endtask

  task automatic add_position(logic ls, logic [5:0] col);
    logic [6:0] addr;
    addr = {1'b0, col};
    if (ls) begin
      addr = addr + LINE2_BASE;
    end
    add_byte(POS_BASE | {1'b0, addr}, 1'b0, 4'd1);
  endtask

  task automatic expand_request(lcd_req_t r);
    bus_xfer_t x;
    run_q.delete();
    case (r.cmd)
      CMD_INIT: begin
        backlight_q = 1'b1;
        add_xfer(4'h0, 1'b0, 1'b0, 4'd15);
        add_xfer(LCD_WAKE[3:0], 1'b0, 1'b1, 4'd5);
        add_xfer(LCD_WAKE[3:0], 1'b0, 1'b1, 4'd1);
        add_xfer(LCD_WAKE[3:0], 1'b0, 1'b1, 4'd1);
        add_xfer(LCD_4BIT[3:0], 1'b0, 1'b1, 4'd1);
        add_byte(LCD_FUNC_SET, 1'b0, 4'd1);
        add_byte(LCD_DISP_CUR, 1'b0, 4'd1);
        add_byte(LCD_CLEAR, 1'b0, 4'd2);
        add_byte(LCD_ENTRY, 1'b0, 4'd1);
        add_byte(LCD_HOME_POS, 1'b0, 4'd1);
      end
      CMD_CHAR: add_byte(r.ch, 1'b1, 4'd1);
      CMD_CLEAR: begin
        if (r.opt == OPT_ALL) begin
          add_byte(LCD_CLEAR, 1'b0, 4'd1);
        end else if (r.opt == OPT_LINE1 || r.opt == OPT_LINE2) begin
          add_position(r.opt == OPT_LINE2, 6'd0);
          for (int i = 0; i < LineChars; i++) begin
            add_byte(LCD_SPACE, 1'b1, (i == LineChars - 1) ? 4'd2 : 4'd1);
          end
        end else begin
          add_xfer(4'h0, 1'b0, 1'b0, 4'd1);
        end
      end
      CMD_CURSOR: begin
        if (r.opt == OPT_ON) begin
          add_byte(LCD_DISP_CUR, 1'b0, 4'd1);
        end else if (r.opt == OPT_OFF) begin
          add_byte(LCD_DISP_NCUR, 1'b0, 4'd1);
        end else begin
          add_xfer(4'h0, 1'b0, 1'b0, 4'd1);
        end
      end
      CMD_BACKLIGHT: begin
        if (r.opt == OPT_ON) begin
          backlight_q = 1'b1;
        end else if (r.opt == OPT_OFF) begin
          backlight_q = 1'b0;
        end
        add_xfer(4'h0, 1'b0, 1'b0, 4'd1);
      end
      CMD_POS: add_position(r.line_sel, r.column);
      default: ;
    endcase
    foreach (run_q[i]) begin
      x      = run_q[i];
      x.last = (i == run_q.size() - 1);
      lcd_bus_q.push_back(x);
    end
  endtask

  task automatic add_req(logic [2:0] cmd, logic [7:0] ch, logic [1:0] opt, logic ls,
                         logic [5:0] col, logic drain);
    lcd_req_t r;
    r.cmd      = cmd;
    r.ch       = ch;
    r.opt      = opt;
    r.line_sel = ls;
    r.column   = col;
    r.gap      = send_quiet ? 2'd0 : 2'($urandom_range(0, 3));
    r.drain    = drain;
    request_q.push_back(r);
  endtask

  always @(posedge clk_i) begin : driver
    logic     fire;
    logic     vld;
    lcd_req_t nxt;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      vld  = in_valid_i && !fire;
      if (fire) begin
        expand_request(cur_req);
        hold_cnt = cur_req.gap;
      end
      if (!vld) begin
        if (hold_cnt != 0) begin
          hold_cnt--;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].drain && lcd_bus_q.size() != 0)) begin
          nxt = request_q.pop_front();
          cur_req <= nxt;
          cmd_i <= nxt.cmd;
          char_code_i <= nxt.ch;
          option_i <= nxt.opt;
          line_sel_i <= nxt.line_sel;
          column_i <= nxt.column;
          vld = 1'b1;
        end
      end
      in_valid_i <= vld;
    end
  end

  always @(posedge clk_i) begin : monitor
    bus_xfer_t want;
    logic      rdy;
    logic      recv_quiet;
    int        seen;
    if (rst_ni) begin
      rdy = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (lcd_bus_q.size() == 0) begin
          report_mismatch("transfer with nothing pending, nibble", nibble_o, 0);
        end else begin
          want = lcd_bus_q.pop_front();
          if (nibble_o !== want.nibble) report_mismatch("nibble", nibble_o, want.nibble);
          if (reg_select_o !== want.rs) report_mismatch("reg_select", reg_select_o, want.rs);
          if (strobe_res_o !== want.strobe) begin
            report_mismatch("strobe_res", strobe_res_o, want.strobe);
          end
          if (backlight_o !== want.bl) report_mismatch("backlight", backlight_o, want.bl);
          if (wait_ms_o !== want.wait_ms) report_mismatch("wait_ms", wait_ms_o, want.wait_ms);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
        seen++;
        if (seen % 64 == 1) begin
          recv_quiet = ($urandom_range(0, 2) == 0);
        end
        stall_cnt = recv_quiet ? 0 : $urandom_range(0, 3);
        rdy = (stall_cnt == 0);
      end else if (!out_ready_i) begin
        if (stall_cnt > 1) begin
          stall_cnt--;
        end else begin
          stall_cnt = 0;
          rdy = 1'b1;
        end
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int         n;
    int         p;
    logic [2:0] c;
    logic [1:0] o;
    add_req(CMD_INIT, 8'h3C, OPT_RSVD3, 1'b1, 6'h2A, 1'b0);
    add_req(CMD_CHAR, 8'h00, OPT_OFF, 1'b0, 6'h00, 1'b0);
    add_req(CMD_CHAR, 8'hFF, OPT_RSVD3, 1'b1, 6'h3F, 1'b0);
    add_req(CMD_CHAR, 8'hA5, OPT_ON, 1'b0, 6'h15, 1'b0);
    add_req(CMD_CLEAR, 8'h5A, OPT_ALL, 1'b1, 6'h2A, 1'b0);
    add_req(CMD_CLEAR, 8'h00, OPT_LINE1, 1'b0, 6'h3F, 1'b0);
    add_req(CMD_CLEAR, 8'hFF, OPT_LINE2, 1'b1, 6'h00, 1'b0);
    add_req(CMD_CLEAR, 8'h81, OPT_RSVD3, 1'b0, 6'h11, 1'b1);
    add_req(CMD_CURSOR, 8'h18, OPT_OFF, 1'b1, 6'h22, 1'b0);
    add_req(CMD_CURSOR, 8'h42, OPT_ON, 1'b0, 6'h0C, 1'b0);
    add_req(CMD_CURSOR, 8'hE7, OPT_RSVD2, 1'b1, 6'h30, 1'b0);
    add_req(CMD_CURSOR, 8'h24, OPT_RSVD3, 1'b0, 6'h03, 1'b0);
    add_req(CMD_BACKLIGHT, 8'h99, OPT_OFF, 1'b1, 6'h1E, 1'b0);
    add_req(CMD_CHAR, 8'h5A, OPT_ALL, 1'b0, 6'h21, 1'b0);
    add_req(CMD_BACKLIGHT, 8'h66, OPT_RSVD2, 1'b0, 6'h2D, 1'b0);
    add_req(CMD_BACKLIGHT, 8'hC3, OPT_RSVD3, 1'b1, 6'h12, 1'b0);
    add_req(CMD_BACKLIGHT, 8'h3C, OPT_ON, 1'b0, 6'h0F, 1'b0);
    add_req(CMD_POS, 8'h7E, OPT_ALL, 1'b0, 6'd0, 1'b0);
    add_req(CMD_POS, 8'h81, OPT_LINE1, 1'b1, 6'd63, 1'b0);
    add_req(CMD_POS, 8'h18, OPT_RSVD3, 1'b0, 6'd63, 1'b0);
    add_req(CMD_POS, 8'hE7, OPT_LINE2, 1'b1, 6'd0, 1'b0);
    add_req(CMD_RSVD6, 8'hFF, OPT_RSVD3, 1'b1, 6'h3F, 1'b0);
    add_req(CMD_RSVD7, 8'h00, OPT_OFF, 1'b0, 6'h00, 1'b0);
    add_req(CMD_BACKLIGHT, 8'h55, OPT_OFF, 1'b0, 6'h2A, 1'b0);
    add_req(CMD_INIT, 8'hAA, OPT_LINE1, 1'b1, 6'h15, 1'b1);

    n = 0;
    while (n < RandItems) begin
      if (n % 50 == 0) begin
        send_quiet = ($urandom_range(0, 2) == 0);
      end
      p = $urandom_range(0, 99);
      if (p < 5) begin
        c = CMD_INIT;
      end else if (p < 40) begin
        c = CMD_CHAR;
      end else if (p < 52) begin
        c = CMD_CLEAR;
      end else if (p < 64) begin
        c = CMD_CURSOR;
      end else if (p < 76) begin
        c = CMD_BACKLIGHT;
      end else if (p < 96) begin
        c = CMD_POS;
      end else begin
        c = (p % 2 == 0) ? CMD_RSVD6 : CMD_RSVD7;
      end
      o = ($urandom_range(0, 9) == 0) ? OPT_RSVD3 : 2'($urandom_range(0, 2));
      add_req(c, 8'($urandom), o, 1'($urandom), 6'($urandom), $urandom_range(0, 59) == 0);
      if (c != CMD_RSVD6 && c != CMD_RSVD7) begin
        n++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (lcd_bus_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
